@@ hw/rtl/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic ease envelope package
// Shared widths, register indexes, curve codes and sine coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

   // Default values of the top-level parameters.
   localparam int TIME_WIDTH_DEFAULT    = 32;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // Register and field widths.
   localparam int LEN_WIDTH       = 24;
   localparam int START_WIDTH     = 32;
   localparam int CURVE_WIDTH     = 3;
   localparam int LEVEL_WIDTH     = 17;
   localparam int LEVEL_FRACTION  = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_LENGTH   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_TIME      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FADE_IN_LENGTH  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FADE_IN_CURVE   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FADE_OUT_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FADE_OUT_CURVE  = 3'd5;

   // Curve codes.
   localparam logic [CURVE_WIDTH-1:0] CURVE_NONE       = 3'd0;
   localparam logic [CURVE_WIDTH-1:0] CURVE_LINEAR     = 3'd1;
   localparam logic [CURVE_WIDTH-1:0] CURVE_SQRT       = 3'd2;
   localparam logic [CURVE_WIDTH-1:0] CURVE_SQUARE     = 3'd3;
   localparam logic [CURVE_WIDTH-1:0] CURVE_SINE_INOUT = 3'd4;
   localparam logic [CURVE_WIDTH-1:0] CURVE_SINE_IN    = 3'd5;
   localparam logic [CURVE_WIDTH-1:0] CURVE_SINE_OUT   = 3'd6;

   // Reset values of the registers.
   localparam logic [LEN_WIDTH-1:0]   RESET_PERIOD_LENGTH = 24'd2000;
   localparam logic [START_WIDTH-1:0] RESET_START_TIME    = 32'd0;
   localparam logic [LEN_WIDTH-1:0]   RESET_FADE_LENGTH   = 24'd1000;
   localparam logic [CURVE_WIDTH-1:0] RESET_CURVE         = CURVE_LINEAR;

   // Sine polynomial in unsigned Q30 Horner form.
   localparam int Q_BITS     = 30;
   localparam int QW         = Q_BITS + 1;
   localparam int COEF_WIDTH = 32;
   localparam logic [COEF_WIDTH-1:0] SINE_C9 = 32'd172272;
   localparam logic [COEF_WIDTH-1:0] SINE_COEF [4] = '{
      32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
   };

endpackage

`default_nettype wire

@@ hw/rtl/pee_mod_cell.sv @@
// ----------------------------------------------------------------------------
// Phase remainder cell
// One restoring step of the time-difference modulo: takes the next magnitude
// bit into the partial remainder and subtracts the period when it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_mod_cell #(
   parameter int TIME_WIDTH = pee_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pee_pkg::LEN_WIDTH-1:0]  period,
   input  logic                           in_valid,
   input  logic                           in_neg,
   input  logic [TIME_WIDTH-1:0]          in_mag,
   input  logic [pee_pkg::LEN_WIDTH-1:0]  in_rem,
   output logic                           out_valid,
   output logic                           out_neg,
   output logic [TIME_WIDTH-1:0]          out_mag,
   output logic [pee_pkg::LEN_WIDTH-1:0]  out_rem
);
   import pee_pkg::*;

   logic                  valid_ff;
   logic                  neg_ff;
   logic [TIME_WIDTH-1:0] mag_ff;
   logic [LEN_WIDTH-1:0]  rem_ff;
   logic [LEN_WIDTH-1:0]  rem_in;
   logic [LEN_WIDTH:0]    shifted;

   // Bring in the top magnitude bit and reduce by the period.
   always_comb begin
      shifted = {in_rem, in_mag[TIME_WIDTH-1]};
      if (shifted >= {1'b0, period}) begin
         rem_in = LEN_WIDTH'(shifted - {1'b0, period});
      end else begin
         rem_in = shifted[LEN_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      neg_ff <= in_neg;
      mag_ff <= in_mag << 1;
      rem_ff <= rem_in;
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_mag   = mag_ff;
   assign out_rem   = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pee_div_cell.sv @@
// ----------------------------------------------------------------------------
// Ramp argument divider cell
// One restoring quotient bit for both the fade-in and fade-out arguments.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_div_cell #(
   parameter int FRACTION_BITS = pee_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pee_pkg::LEN_WIDTH-1:0] fi_len,
   input  logic [pee_pkg::LEN_WIDTH-1:0] fo_len,
   input  logic                          in_valid,
   input  logic [pee_pkg::LEN_WIDTH-1:0] in_fi_rem,
   input  logic [FRACTION_BITS-1:0]      in_fi_quo,
   input  logic                          in_fi_sat,
   input  logic [pee_pkg::LEN_WIDTH-1:0] in_fo_rem,
   input  logic [FRACTION_BITS-1:0]      in_fo_quo,
   input  logic                          in_fo_sat,
   output logic                          out_valid,
   output logic [pee_pkg::LEN_WIDTH-1:0] out_fi_rem,
   output logic [FRACTION_BITS-1:0]      out_fi_quo,
   output logic                          out_fi_sat,
   output logic [pee_pkg::LEN_WIDTH-1:0] out_fo_rem,
   output logic [FRACTION_BITS-1:0]      out_fo_quo,
   output logic                          out_fo_sat
);
   import pee_pkg::*;

   logic                     valid_ff;
   logic [LEN_WIDTH-1:0]     fi_rem_ff, fo_rem_ff;
   logic [FRACTION_BITS-1:0] fi_quo_ff, fo_quo_ff;
   logic                     fi_sat_ff, fo_sat_ff;
   logic [LEN_WIDTH-1:0]     fi_rem_in, fo_rem_in;
   logic [LEN_WIDTH:0]       fi_shift, fo_shift;
   logic                     fi_ge, fo_ge;

   // Fade-in lane: double the remainder and try the length.
   always_comb begin
      fi_shift = {in_fi_rem, 1'b0};
      fi_ge    = fi_shift >= {1'b0, fi_len};
      if (fi_ge) begin
         fi_rem_in = LEN_WIDTH'(fi_shift - {1'b0, fi_len});
      end else begin
         fi_rem_in = fi_shift[LEN_WIDTH-1:0];
      end
   end

   // Fade-out lane: the same step on its own length.
   always_comb begin
      fo_shift = {in_fo_rem, 1'b0};
      fo_ge    = fo_shift >= {1'b0, fo_len};
      if (fo_ge) begin
         fo_rem_in = LEN_WIDTH'(fo_shift - {1'b0, fo_len});
      end else begin
         fo_rem_in = fo_shift[LEN_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      fi_rem_ff <= fi_rem_in;
      fo_rem_ff <= fo_rem_in;
      fi_quo_ff <= {in_fi_quo[FRACTION_BITS-2:0], fi_ge};
      fo_quo_ff <= {in_fo_quo[FRACTION_BITS-2:0], fo_ge};
      fi_sat_ff <= in_fi_sat;
      fo_sat_ff <= in_fo_sat;
   end

   assign out_valid  = valid_ff;
   assign out_fi_rem = fi_rem_ff;
   assign out_fi_quo = fi_quo_ff;
   assign out_fi_sat = fi_sat_ff;
   assign out_fo_rem = fo_rem_ff;
   assign out_fo_quo = fo_quo_ff;
   assign out_fo_sat = fo_sat_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pee_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit step of the integer square root: two radicand bits in,
// one root bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_sqrt_cell #(
   parameter int FRACTION_BITS = pee_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic [2*FRACTION_BITS+1:0]   in_rad,
   input  logic [FRACTION_BITS+3:0]     in_rem,
   input  logic [FRACTION_BITS:0]       in_root,
   output logic [2*FRACTION_BITS+1:0]   out_rad,
   output logic [FRACTION_BITS+3:0]     out_rem,
   output logic [FRACTION_BITS:0]       out_root
);
   localparam int RAD_W  = 2 * FRACTION_BITS + 2;
   localparam int REM_W  = FRACTION_BITS + 4;
   localparam int ROOT_W = FRACTION_BITS + 1;

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic [REM_W-1:0]  rem_in;
   logic              ge;

   // Trial subtraction of 4*root + 1.
   always_comb begin
      rem_shift = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
      trial     = REM_W'({in_root, 2'b01});
      ge        = rem_shift >= trial;
      rem_in    = ge ? rem_shift - trial : rem_shift;
   end

   always_ff @(posedge clock) begin
      rad_ff  <= in_rad << 2;
      rem_ff  <= rem_in;
      root_ff <= {in_root[ROOT_W-2:0], ge};
   end

   assign out_rad  = rad_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pee_curve.sv @@
// ----------------------------------------------------------------------------
// Easing curve unit
// Pipelined shaping of one ramp argument: square root cells, a Horner sine
// pipeline and a final selection stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_curve #(
   parameter int FRACTION_BITS = pee_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic [FRACTION_BITS:0]          in_arg,
   input  logic [pee_pkg::CURVE_WIDTH-1:0] in_curve,
   output logic [FRACTION_BITS:0]          out_value
);
   import pee_pkg::*;

   localparam int VW       = FRACTION_BITS + 1;
   localparam int STEPS    = FRACTION_BITS + 1;
   localparam int RAD_W    = 2 * FRACTION_BITS + 2;
   localparam int REM_W    = FRACTION_BITS + 4;
   localparam int SHIFT    = Q_BITS - FRACTION_BITS;
   localparam int HOLD     = FRACTION_BITS - 5;
   localparam int PROD_W   = QW + COEF_WIDTH;
   localparam int SQ_W     = 2 * VW + 1;
   localparam logic [VW-1:0]   ONE     = VW'(1) << FRACTION_BITS;
   localparam logic [SQ_W-1:0] HALF_SQ = SQ_W'(1) << (FRACTION_BITS - 1);
   localparam logic [PROD_W-Q_BITS-1:0] ROUND_S =
      (PROD_W - Q_BITS)'(1) << (SHIFT - 1);

   // Sine pipeline storage.
   logic [QW-1:0]         u30_ff [5];
   logic [QW-1:0]         u2_ff  [4];
   logic [COEF_WIDTH-1:0] t_ff   [4];
   logic [COEF_WIDTH-1:0] t_prev [4];
   logic [PROD_W-1:0]     t_prod [4];
   logic [VW-1:0]         s_ff;
   logic [VW-1:0]         s_dly  [HOLD];
   // Argument and curve code ride alongside.
   logic [VW-1:0]          x_dly   [STEPS];
   logic [CURVE_WIDTH-1:0] sel_dly [STEPS];
   // Square root chain.
   logic [RAD_W-1:0] rad  [STEPS+1];
   logic [REM_W-1:0] rem  [STEPS+1];
   logic [VW-1:0]    root [STEPS+1];

   logic [VW-1:0]            u_w;
   logic [QW-1:0]            u30_w;
   logic [2*QW-1:0]          u_sq;
   logic [PROD_W-1:0]        s_prod;
   logic [PROD_W-Q_BITS-1:0] s_round;
   logic [PROD_W-Q_BITS-1:0] s_scaled;
   logic [2*VW-1:0]          x_prod, s_prod2;
   logic [SQ_W-1:0]          x_sq, s_sq;
   logic [VW-1:0]            x_last, s_last, value_in, out_ff;
   logic [CURVE_WIDTH-1:0]   sel_last;

   // Sine input: sine-in evaluates the curve on the mirrored argument.
   always_comb begin
      u_w   = (in_curve == CURVE_SINE_IN) ? ONE - in_arg : in_arg;
      u30_w = QW'(u_w) << SHIFT;
      u_sq  = u30_w * u30_w;
   end

   always_ff @(posedge clock) begin
      u30_ff[0] <= u30_w;
      u2_ff[0]  <= u_sq[Q_BITS +: QW];
   end

   // Horner cells, one coefficient each.
   for (genvar k = 0; k < 4; k++) begin : g_horner
      if (k == 0) begin : g_first
         assign t_prev[k] = SINE_C9;
      end else begin : g_next
         assign t_prev[k] = t_ff[k-1];
      end
      assign t_prod[k] = u2_ff[k] * t_prev[k];
      always_ff @(posedge clock) begin
         t_ff[k]     <= SINE_COEF[k] - COEF_WIDTH'(t_prod[k] >> Q_BITS);
         u30_ff[k+1] <= u30_ff[k];
      end
      if (k < 3) begin : g_carry
         always_ff @(posedge clock) begin
            u2_ff[k+1] <= u2_ff[k];
         end
      end
   end

   // Final odd factor, round to the output fraction and clamp at one.
   always_comb begin
      s_prod   = u30_ff[4] * t_ff[3];
      s_round  = s_prod[PROD_W-1:Q_BITS] + ROUND_S;
      s_scaled = s_round >> SHIFT;
   end

   always_ff @(posedge clock) begin
      s_ff <= (s_scaled > (PROD_W - Q_BITS)'(ONE)) ? ONE : VW'(s_scaled);
   end

   // Hold the sine value until the square root chain catches up.
   always_ff @(posedge clock) begin
      s_dly[0] <= s_ff;
      for (int i = 1; i < HOLD; i++) begin
         s_dly[i] <= s_dly[i-1];
      end
   end

   always_ff @(posedge clock) begin
      x_dly[0]   <= in_arg;
      sel_dly[0] <= in_curve;
      for (int i = 1; i < STEPS; i++) begin
         x_dly[i]   <= x_dly[i-1];
         sel_dly[i] <= sel_dly[i-1];
      end
   end

   // Square root of the argument scaled up by one fraction width.
   assign rad[0]  = RAD_W'(in_arg) << FRACTION_BITS;
   assign rem[0]  = '0;
   assign root[0] = '0;

   for (genvar i = 0; i < STEPS; i++) begin : g_sqrt
      pee_sqrt_cell #(
         .FRACTION_BITS(FRACTION_BITS)
      ) u_cell (
         .clock   (clock),
         .in_rad  (rad[i]),
         .in_rem  (rem[i]),
         .in_root (root[i]),
         .out_rad (rad[i+1]),
         .out_rem (rem[i+1]),
         .out_root(root[i+1])
      );
   end

   // Square terms and curve selection.
   assign x_last   = x_dly[STEPS-1];
   assign sel_last = sel_dly[STEPS-1];
   assign s_last   = s_dly[HOLD-1];
   assign x_prod   = x_last * x_last;
   assign s_prod2  = s_last * s_last;
   assign x_sq     = SQ_W'(x_prod) + HALF_SQ;
   assign s_sq     = SQ_W'(s_prod2) + HALF_SQ;

   always_comb begin
      unique case (sel_last)
         CURVE_NONE:       value_in = ONE;
         CURVE_LINEAR:     value_in = x_last;
         CURVE_SQRT:       value_in = root[STEPS];
         CURVE_SQUARE:     value_in = VW'(x_sq >> FRACTION_BITS);
         CURVE_SINE_INOUT: value_in = VW'(s_sq >> FRACTION_BITS);
         CURVE_SINE_IN:    value_in = ONE - s_last;
         CURVE_SINE_OUT:   value_in = s_last;
         default:          value_in = ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      out_ff <= value_in;
   end

   assign out_value = out_ff;

endmodule

`default_nettype wire

@@ hw/rtl/periodic_ease_envelope_top.sv @@
// ----------------------------------------------------------------------------
// Periodic ease envelope
// Turns each timestamp into a fade-in / fade-out envelope level in Q16.
// ----------------------------------------------------------------------------
// Usage:
//   A timestamp word is taken on req_time_now at a clock edge where start is
//   high and busy is low. Exactly one level word comes back on
//   rsp_ease_level, marked by rsp_strobe for one cycle, in request order.
//   The path runs through TIME_WIDTH remainder cells for the phase, one
//   phase stage, FRACTION_BITS divider cells for both ramp arguments,
//   FRACTION_BITS + 2 stages in each curve unit and one output stage.
//   Every stage is a register, so a new timestamp may enter every cycle
//   while busy is low, and every stage can hold a word in flight.
//   busy is high for one cycle after reset and low from then on; reset also
//   loads the register defaults and drops every word in flight.
//   The receiver must take each word in its strobe cycle; it cannot stall.
//   Registers on the csr_ port are written at any edge with csr_write_enable
//   high and reset low; change them only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_ease_envelope_top #(
   parameter int TIME_WIDTH    = pee_pkg::TIME_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = pee_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [TIME_WIDTH-1:0]               req_time_now,
   output logic                                rsp_strobe,
   output logic [pee_pkg::LEVEL_WIDTH-1:0]     rsp_ease_level,
   input  logic                                csr_write_enable,
   input  logic [pee_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pee_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import pee_pkg::*;

   localparam int VW        = FRACTION_BITS + 1;
   localparam int C_LAT     = FRACTION_BITS + 2;
   localparam int LVL_SUM_W = VW + LEVEL_FRACTION + 1;
   localparam logic [VW-1:0] ONE = VW'(1) << FRACTION_BITS;
   localparam logic [LVL_SUM_W-1:0] HALF = LVL_SUM_W'(1) << (FRACTION_BITS - 1);

   // Configuration registers.
   logic [LEN_WIDTH-1:0]   period_length_ff;
   logic [START_WIDTH-1:0] start_time_ff;
   logic [LEN_WIDTH-1:0]   fade_in_length_ff;
   logic [CURVE_WIDTH-1:0] fade_in_curve_ff;
   logic [LEN_WIDTH-1:0]   fade_out_length_ff;
   logic [CURVE_WIDTH-1:0] fade_out_curve_ff;
   logic                   busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_length_ff   <= RESET_PERIOD_LENGTH;
         start_time_ff      <= RESET_START_TIME;
         fade_in_length_ff  <= RESET_FADE_LENGTH;
         fade_in_curve_ff   <= RESET_CURVE;
         fade_out_length_ff <= RESET_FADE_LENGTH;
         fade_out_curve_ff  <= RESET_CURVE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PERIOD_LENGTH:   period_length_ff   <= LEN_WIDTH'(csr_write_data);
            CSR_START_TIME:      start_time_ff      <= START_WIDTH'(csr_write_data);
            CSR_FADE_IN_LENGTH:  fade_in_length_ff  <= LEN_WIDTH'(csr_write_data);
            CSR_FADE_IN_CURVE:   fade_in_curve_ff   <= CURVE_WIDTH'(csr_write_data);
            CSR_FADE_OUT_LENGTH: fade_out_length_ff <= LEN_WIDTH'(csr_write_data);
            CSR_FADE_OUT_CURVE:  fade_out_curve_ff  <= CURVE_WIDTH'(csr_write_data);
            default: ;
         endcase
      end
   end

   // Busy only in the cycle after reset.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   // A zero period behaves as a period of one.
   logic [LEN_WIDTH-1:0] period_eff;
   assign period_eff = (period_length_ff == '0) ? LEN_WIDTH'(1) : period_length_ff;

   // Signed difference to the start time, split into sign and magnitude.
   logic                  accept;
   logic [TIME_WIDTH-1:0] diff;
   logic [TIME_WIDTH-1:0] mag;
   assign accept = start && !busy_ff;
   assign diff   = req_time_now - TIME_WIDTH'(start_time_ff);
   assign mag    = diff[TIME_WIDTH-1] ? TIME_WIDTH'(0) - diff : diff;

   // Remainder chain, one magnitude bit per cell.
   logic                  m_valid [TIME_WIDTH+1];
   logic                  m_neg   [TIME_WIDTH+1];
   logic [TIME_WIDTH-1:0] m_mag   [TIME_WIDTH+1];
   logic [LEN_WIDTH-1:0]  m_rem   [TIME_WIDTH+1];

   assign m_valid[0] = accept;
   assign m_neg[0]   = diff[TIME_WIDTH-1];
   assign m_mag[0]   = mag;
   assign m_rem[0]   = '0;

   for (genvar i = 0; i < TIME_WIDTH; i++) begin : g_mod
      pee_mod_cell #(
         .TIME_WIDTH(TIME_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .period   (period_eff),
         .in_valid (m_valid[i]),
         .in_neg   (m_neg[i]),
         .in_mag   (m_mag[i]),
         .in_rem   (m_rem[i]),
         .out_valid(m_valid[i+1]),
         .out_neg  (m_neg[i+1]),
         .out_mag  (m_mag[i+1]),
         .out_rem  (m_rem[i+1])
      );
   end

   // Floor-mod phase and the distance left to the cycle end.
   logic                 phase_valid_ff;
   logic [LEN_WIDTH-1:0] phase_ff, remain_ff, phase_in, mod_rem;
   assign mod_rem  = m_rem[TIME_WIDTH];
   assign phase_in = (m_neg[TIME_WIDTH] && mod_rem != '0) ? period_eff - mod_rem : mod_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_valid_ff <= 1'b0;
      end else begin
         phase_valid_ff <= m_valid[TIME_WIDTH];
      end
      phase_ff  <= phase_in;
      remain_ff <= period_eff - phase_in;
   end

   // Divider chain for both ramp arguments.
   logic                     d_valid  [FRACTION_BITS+1];
   logic [LEN_WIDTH-1:0]     d_fi_rem [FRACTION_BITS+1];
   logic [FRACTION_BITS-1:0] d_fi_quo [FRACTION_BITS+1];
   logic                     d_fi_sat [FRACTION_BITS+1];
   logic [LEN_WIDTH-1:0]     d_fo_rem [FRACTION_BITS+1];
   logic [FRACTION_BITS-1:0] d_fo_quo [FRACTION_BITS+1];
   logic                     d_fo_sat [FRACTION_BITS+1];

   // Zero length or a numerator at least the length saturates to one.
   assign d_valid[0]  = phase_valid_ff;
   assign d_fi_rem[0] = phase_ff;
   assign d_fi_quo[0] = '0;
   assign d_fi_sat[0] = (fade_in_length_ff == '0) || (phase_ff >= fade_in_length_ff);
   assign d_fo_rem[0] = remain_ff;
   assign d_fo_quo[0] = '0;
   assign d_fo_sat[0] = (fade_out_length_ff == '0) || (remain_ff >= fade_out_length_ff);

   for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_div
      pee_div_cell #(
         .FRACTION_BITS(FRACTION_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .fi_len    (fade_in_length_ff),
         .fo_len    (fade_out_length_ff),
         .in_valid  (d_valid[i]),
         .in_fi_rem (d_fi_rem[i]),
         .in_fi_quo (d_fi_quo[i]),
         .in_fi_sat (d_fi_sat[i]),
         .in_fo_rem (d_fo_rem[i]),
         .in_fo_quo (d_fo_quo[i]),
         .in_fo_sat (d_fo_sat[i]),
         .out_valid (d_valid[i+1]),
         .out_fi_rem(d_fi_rem[i+1]),
         .out_fi_quo(d_fi_quo[i+1]),
         .out_fi_sat(d_fi_sat[i+1]),
         .out_fo_rem(d_fo_rem[i+1]),
         .out_fo_quo(d_fo_quo[i+1]),
         .out_fo_sat(d_fo_sat[i+1])
      );
   end

   logic [VW-1:0] fi_arg, fo_arg, fi_value, fo_value;
   assign fi_arg = d_fi_sat[FRACTION_BITS] ? ONE : {1'b0, d_fi_quo[FRACTION_BITS]};
   assign fo_arg = d_fo_sat[FRACTION_BITS] ? ONE : {1'b0, d_fo_quo[FRACTION_BITS]};

   // Curve units; the user must keep the curve codes steady while words are in flight, the block does not enforce it.
   pee_curve #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_fade_in_curve (
      .clock    (clock),
      .in_arg   (fi_arg),
      .in_curve (fade_in_curve_ff),
      .out_value(fi_value)
   );

   pee_curve #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_fade_out_curve (
      .clock    (clock),
      .in_arg   (fo_arg),
      .in_curve (fade_out_curve_ff),
      .out_value(fo_value)
   );

   // Valid bits that follow the words through the curve units.
   logic c_valid_ff [C_LAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < C_LAT; i++) begin
            c_valid_ff[i] <= 1'b0;
         end
      end else begin
         c_valid_ff[0] <= d_valid[FRACTION_BITS];
         for (int i = 1; i < C_LAT; i++) begin
            c_valid_ff[i] <= c_valid_ff[i-1];
         end
      end
   end

   // Smaller of the two curves, rescaled to Q16 with rounding.
   logic [VW-1:0]          level_min;
   logic [LVL_SUM_W-1:0]   level_sum;
   logic                   rsp_strobe_ff;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff;
   assign level_min = (fi_value < fo_value) ? fi_value : fo_value;
   assign level_sum = LVL_SUM_W'({level_min, {LEVEL_FRACTION{1'b0}}}) + HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= c_valid_ff[C_LAT-1];
      end
      rsp_level_ff <= LEVEL_WIDTH'(level_sum >> FRACTION_BITS);
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_ease_level = rsp_level_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pee_checker.sv @@
// ----------------------------------------------------------------------------
// Periodic ease envelope checker
// Port-level assertions on reset, busy, latency and level range.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_checker #(
   parameter int TIME_WIDTH    = pee_pkg::TIME_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = pee_pkg::FRACTION_BITS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic [pee_pkg::LEVEL_WIDTH-1:0] rsp_ease_level
);
   import pee_pkg::*;

   localparam int LATENCY = TIME_WIDTH + 2 * FRACTION_BITS + 4;
   localparam logic [LEVEL_WIDTH-1:0] FULL_LEVEL = LEVEL_WIDTH'(1) << LEVEL_FRACTION;

   // Reset flushes the pipeline and raises busy for one cycle.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> (busy && !rsp_strobe))
      else $error("reset did not flush the pipeline");

   // Outside reset the block always takes words.
   a_never_busy: assert property (@(posedge clock)
      !reset |=> !busy)
      else $error("busy raised outside reset");

   // Every level word answers an earlier request taken with start high and busy low.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("level word without a matching request");

   // The level never exceeds full scale.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ease_level <= FULL_LEVEL))
      else $error("level word above full scale");

endmodule

bind periodic_ease_envelope_top pee_checker #(
   .TIME_WIDTH   (TIME_WIDTH),
   .FRACTION_BITS(FRACTION_BITS)
) u_pee_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_ease_level(rsp_ease_level)
);

`default_nettype wire
